@@ rtl/wgm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wgm_pkg: wildcard glob match shared definitions
// Widths, item types, register indexes and the helpers for the matcher.
// ----------------------------------------------------------------------------
package wgm_pkg;

  localparam int PATTERN_MAX = 16;
  localparam int REG_SLOTS   = 16;
  // Usable pattern positions: the smaller of register slots and PATTERN_MAX
  localparam int EFF_MAX     = (PATTERN_MAX < REG_SLOTS) ? PATTERN_MAX : REG_SLOTS;
  localparam int POS_N       = EFF_MAX + 1;
  localparam int POS_IDX_W   = $clog2(POS_N);
  localparam int LEN_W       = 5;
  localparam int CHAR_W      = 8;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_QMARK = 8'h3F;
  localparam logic [CHAR_W-1:0] CH_LOW_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOW_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CASE_GAP = 8'h20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHARS_LOW  = 2'd0,
    CFG_CHARS_HIGH = 2'd1,
    CFG_LENGTH     = 2'd2
  } cfg_idx_e;

  typedef logic [POS_N-1:0]   pos_t;
  typedef logic [EFF_MAX-1:0] star_t;

  typedef struct packed {
    logic [CHAR_W-1:0] text_char;
    logic              no_char;
    logic              end_of_text;
  } text_item_t;

  typedef struct packed {
    logic matched;
  } result_item_t;

  function automatic logic [CHAR_W-1:0] upcase(logic [CHAR_W-1:0] c);
    return (c >= CH_LOW_A && c <= CH_LOW_Z) ? c - CASE_GAP : c;
  endfunction

  // Extend each active position forward through any run of star characters
  function automatic pos_t star_closure(pos_t v, star_t se);
    pos_t r;
    logic t;
    r = '0;
    for (int q = 0; q < POS_N; q++) begin
      for (int p = 0; p <= q; p++) begin
        t = v[p];
        for (int k = p; k < q; k++) begin
          t = t & se[k];
        end
        r[q] = r[q] | t;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/wgm_ifs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wgm_ifs: wildcard glob match stream channels
// Valid/ready channels for text items and result items.
// ----------------------------------------------------------------------------
interface wgm_text_if;
  logic                  valid;
  logic                  ready;
  wgm_pkg::text_item_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface wgm_result_if;
  logic                  valid;
  logic                  ready;
  wgm_pkg::result_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/wildcard_glob_match_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wildcard_glob_match_core: streamed case-insensitive glob matcher
// Tracks the set of reachable pattern positions, one text byte per item.
// ----------------------------------------------------------------------------
// The block takes one text item per clock cycle, sustained while no end item
// waits behind an untaken result. Each item is captured in an input
// register, and from there one shallow update of the active-position vector
// (per-position compare, then star extension) writes the new vector back;
// that feedback loop through the active-position register sets the rate. An
// end item writes its matched result into the output register at the same
// edge at which it leaves the input register. The result register decouples
// the output side: input items keep flowing while a result waits, and only
// an end item stalls behind an untaken result. Configuration writes restart
// the string in progress and are meant to be issued while the block is idle.
// ----------------------------------------------------------------------------
module wildcard_glob_match_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [wgm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [wgm_pkg::CFG_W-1:0]           cfg_data_i,
  wgm_text_if.sink                                 in_i,
  wgm_result_if.source                             out_o
);

  // Configuration
  logic [wgm_pkg::CFG_W-1:0] chars_low_q, chars_high_q;
  logic [wgm_pkg::LEN_W-1:0] len_q;

  // Input stage
  logic                 in_valid_q;
  wgm_pkg::text_item_t  in_item_q;

  // Match state: fresh_q means the active set is the restart set
  wgm_pkg::pos_t active_q, active_d;
  logic          fresh_q, fresh_d;

  // Result stage
  logic out_valid_q;
  logic out_matched_q, out_matched_d;

  logic [2*wgm_pkg::CFG_W-1:0] chars;
  logic [wgm_pkg::CHAR_W-1:0]  pat [wgm_pkg::EFF_MAX];
  logic [wgm_pkg::LEN_W-1:0]   eff_len;
  logic [wgm_pkg::POS_IDX_W-1:0] eff_idx;
  wgm_pkg::star_t              star_en;
  wgm_pkg::pos_t               restart_vec, cur, step, nxt;
  logic                        cfg_restart;
  logic                        out_free, advance, in_ready;

  assign chars   = {chars_high_q, chars_low_q};
  assign eff_len = (len_q > wgm_pkg::LEN_W'(wgm_pkg::EFF_MAX))
                   ? wgm_pkg::LEN_W'(wgm_pkg::EFF_MAX) : len_q;
  assign eff_idx = eff_len[wgm_pkg::POS_IDX_W-1:0];

  always_comb begin
    for (int i = 0; i < wgm_pkg::EFF_MAX; i++) begin
      pat[i]     = chars[8*i +: 8];
      star_en[i] = (wgm_pkg::LEN_W'(i) < eff_len) && (pat[i] == wgm_pkg::CH_STAR);
    end
  end

  assign restart_vec = wgm_pkg::star_closure(wgm_pkg::pos_t'(1), star_en);
  assign cur         = fresh_q ? restart_vec : active_q;

  // One text character: star holds its position, others advance on a match
  always_comb begin
    step = '0;
    for (int p = 0; p < wgm_pkg::EFF_MAX; p++) begin
      if (cur[p] && (wgm_pkg::LEN_W'(p) < eff_len)) begin
        if (pat[p] == wgm_pkg::CH_STAR) begin
          step[p] = 1'b1;
        end else if (pat[p] == wgm_pkg::CH_QMARK ||
                     wgm_pkg::upcase(pat[p]) == wgm_pkg::upcase(in_item_q.text_char)) begin
          step[p+1] = 1'b1;
        end
      end
    end
  end

  assign nxt = in_item_q.no_char ? cur : wgm_pkg::star_closure(step, star_en);

  // Handshake: an end item waits only for a free result register
  assign out_free = !out_valid_q || out_o.ready;
  assign advance  = in_valid_q && (!in_item_q.end_of_text || out_free);
  assign in_ready = !in_valid_q || advance;

  assign in_i.ready         = in_ready;
  assign out_o.valid        = out_valid_q;
  assign out_o.data.matched = out_matched_q;

  always_comb begin
    cfg_restart = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        wgm_pkg::CFG_CHARS_LOW:  cfg_restart = 1'b1;
        wgm_pkg::CFG_CHARS_HIGH: cfg_restart = 1'b1;
        wgm_pkg::CFG_LENGTH:     cfg_restart = 1'b1;
        default:                 cfg_restart = 1'b0;
      endcase
    end
  end

  always_comb begin
    active_d      = active_q;
    fresh_d       = fresh_q;
    out_matched_d = out_matched_q;
    if (advance) begin
      if (in_item_q.end_of_text) begin
        fresh_d       = 1'b1;
        out_matched_d = nxt[eff_idx];
      end else begin
        active_d = nxt;
        fresh_d  = 1'b0;
      end
    end
    if (cfg_restart) begin
      fresh_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chars_low_q  <= '0;
      chars_high_q <= '0;
      len_q        <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        wgm_pkg::CFG_CHARS_LOW:  chars_low_q  <= cfg_data_i;
        wgm_pkg::CFG_CHARS_HIGH: chars_high_q <= cfg_data_i;
        wgm_pkg::CFG_LENGTH:     len_q        <= cfg_data_i[wgm_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      fresh_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= in_i.valid;
      end
      fresh_q <= fresh_d;
      if (advance && in_item_q.end_of_text) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      in_item_q <= in_i.data;
    end
    active_q      <= active_d;
    out_matched_q <= out_matched_d;
  end

  // Assertions
  a_rise_from_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(advance && in_item_q.end_of_text))
    else $error("result appeared without an end item");

  a_end_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_item_q.end_of_text) |-> out_free)
    else $error("end item advanced over an untaken result");

  a_end_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_item_q.end_of_text) |=> fresh_q)
    else $error("active set not restarted after end item");

  a_cfg_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_restart |=> fresh_q)
    else $error("active set not restarted after register write");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> (in_valid_q && in_item_q.end_of_text && out_valid_q))
    else $error("input stalled without a pending result");

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: wildcard glob match core
// Programs patterns through the register port, streams text strings over the
// valid/ready input channel and checks each matched flag against a software
// model of the reachable pattern positions. Idle and stall rates change per
// phase.
// ----------------------------------------------------------------------------
module testbench;
  import wgm_pkg::*;

  // Index with no register behind it; a write there must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  class glob_scoreboard;
    logic [CFG_W-1:0] chars_lo;
    logic [CFG_W-1:0] chars_hi;
    logic [LEN_W-1:0] len_reg;
    pos_t             reach;
    bit               match_q[$];
    int               errors;

    function new();
      chars_lo = '0;
      chars_hi = '0;
      len_reg  = '0;
      errors   = 0;
      restart_string();
    endfunction

    function int used_len();
      return (len_reg > EFF_MAX) ? EFF_MAX : int'(len_reg);
    endfunction

    function logic [CHAR_W-1:0] char_at(int i);
      return (i < 8) ? chars_lo[8*i +: 8] : chars_hi[8*(i-8) +: 8];
    endfunction

    function logic [CHAR_W-1:0] to_upper(logic [CHAR_W-1:0] c);
      return (c >= CH_LOW_A && c <= CH_LOW_Z) ? c - CASE_GAP : c;
    endfunction

    // Walk forward through chained star characters
    function pos_t extend_stars(pos_t v);
      pos_t r;
      int   n;
      r = v;
      n = used_len();
      for (int p = 0; p < n; p++) begin
        if (r[p] && char_at(p) == CH_STAR) r[p+1] = 1'b1;
      end
      return r;
    endfunction

    function void restart_string();
      reach = extend_stars(pos_t'(1));
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_CHARS_LOW: begin
          chars_lo = val;
        end
        CFG_CHARS_HIGH: begin
          chars_hi = val;
        end
        CFG_LENGTH: begin
          len_reg = val[LEN_W-1:0];
        end
        default: begin
          return;
        end
      endcase
      restart_string();
    endfunction

    function void note_text(text_item_t it);
      pos_t              nxt;
      logic [CHAR_W-1:0] pc;
      int                n;
      n = used_len();
      if (!it.no_char) begin
        nxt = '0;
        for (int p = 0; p < n; p++) begin
          if (reach[p]) begin
            pc = char_at(p);
            if (pc == CH_STAR) nxt[p] = 1'b1;
            else if (pc == CH_QMARK || to_upper(pc) == to_upper(it.text_char)) nxt[p+1] = 1'b1;
          end
        end
        reach = extend_stars(nxt);
      end
      if (it.end_of_text) begin
        match_q.push_back(reach[n]);
        restart_string();
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("mismatch: %s", msg);
    endtask

    task check_result(result_item_t r);
      bit want;
      if (match_q.size() == 0) begin
        report($sformatf("result matched=%0b with no string pending", r.matched));
        return;
      end
      want = match_q.pop_front();
      if (r.matched !== want) report($sformatf("matched=%0b, want %0b", r.matched, want));
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  wgm_text_if   text_ch();
  wgm_result_if result_ch();

  glob_scoreboard sb;

  int         send_pct;
  int         stall_pct;
  bit         noise_on;
  int         items_sent;
  logic [7:0] pat_b [16];
  logic [4:0] pat_len_raw;
  logic [7:0] text_q[$];

  wildcard_glob_match_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (text_ch),
    .out_o      (result_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Receiver: ready at random per phase
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      result_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && text_ch.valid && text_ch.ready) sb.note_text(text_ch.data);
    if (rst_ni && result_ch.valid && result_ch.ready) sb.check_result(result_ch.data);
  end

  task automatic push_item(logic [7:0] ch, bit nochar, bit last);
    text_item_t it;
    it.text_char   = ch;
    it.no_char     = nochar;
    it.end_of_text = last;
    if (send_pct > 0 && $urandom_range(99) < send_pct) begin
      text_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_pct);
    end
    text_ch.valid <= 1'b1;
    text_ch.data  <= it;
    do @(posedge clk_i); while (!text_ch.ready);
  endtask

  // Hold the input quiet until every string has reported, then let the pipe empty
  task automatic drain();
    text_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.match_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  task automatic program_pattern();
    logic [63:0] lo;
    logic [63:0] hi;
    for (int i = 0; i < 8; i++) begin
      lo[8*i +: 8] = pat_b[i];
      hi[8*i +: 8] = pat_b[8+i];
    end
    drain();
    write_reg(CFG_CHARS_LOW, lo);
    write_reg(CFG_CHARS_HIGH, hi);
    if ($urandom_range(1)) write_reg(CFG_LENGTH, {32'($urandom), 27'($urandom), pat_len_raw});
    else write_reg(CFG_LENGTH, {59'd0, pat_len_raw});
    cfg_we <= 1'b0;
  endtask

  // Send text_q as one string; the end flag rides on the last byte or on an empty item
  task automatic send_string();
    int n;
    bit sep_end;
    n = text_q.size();
    sep_end = (n == 0) || ($urandom_range(3) == 0);
    for (int i = 0; i < n; i++) begin
      if (noise_on && $urandom_range(99) < 8) push_item(8'($urandom_range(255)), 1'b1, 1'b0);
      push_item(text_q[i], 1'b0, !sep_end && i == n - 1);
      items_sent++;
    end
    if (sep_end) begin
      push_item(8'($urandom_range(255)), 1'b1, 1'b1);
      items_sent++;
    end
  endtask

  function automatic logic [7:0] vary_case(logic [7:0] c);
    if (((c >= 8'h41 && c <= 8'h5A) || (c >= CH_LOW_A && c <= CH_LOW_Z)) && $urandom_range(1))
      return c ^ CASE_GAP;
    return c;
  endfunction

  function automatic logic [7:0] filler();
    if ($urandom_range(1)) return vary_case(8'h41 + 8'($urandom_range(25)));
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] rand_pat_char();
    int r;
    r = $urandom_range(99);
    if (r < 20) return CH_STAR;
    if (r < 35) return CH_QMARK;
    if (r < 75) return vary_case(8'h41 + 8'($urandom_range(25)));
    if (r < 87) begin
      // zero byte, all ones, and the neighbors of the letter ranges
      case ($urandom_range(5))
        0: return 8'h00;
        1: return 8'hFF;
        2: return 8'h40;
        3: return 8'h5B;
        4: return 8'h60;
        default: return 8'h7B;
      endcase
    end
    return 8'($urandom_range(255));
  endfunction

  task automatic random_pattern();
    int r;
    for (int i = 0; i < 16; i++) pat_b[i] = rand_pat_char();
    r = $urandom_range(99);
    if (r < 70) pat_len_raw = 5'($urandom_range(6));
    else if (r < 85) pat_len_raw = 5'($urandom_range(16, 7));
    else if (r < 95) pat_len_raw = 5'd16;
    else pat_len_raw = 5'($urandom_range(31, 17));
  endtask

  // Mostly text that fits the pattern, then perhaps one edit to break it
  task automatic build_text();
    int n;
    int k;
    int pos;
    text_q.delete();
    n = (pat_len_raw > 16) ? 16 : int'(pat_len_raw);
    if ($urandom_range(9) == 0) begin
      k = $urandom_range(8);
      repeat (k) text_q.push_back(filler());
      return;
    end
    for (int i = 0; i < n; i++) begin
      if (pat_b[i] == CH_STAR) repeat ($urandom_range(3)) text_q.push_back(filler());
      else if (pat_b[i] == CH_QMARK) text_q.push_back(8'($urandom_range(255)));
      else text_q.push_back(vary_case(pat_b[i]));
    end
    if ($urandom_range(99) < 35) begin
      pos = $urandom_range(text_q.size());
      case ($urandom_range(4))
        0: begin
          if (pos < text_q.size()) text_q[pos] = filler();
          else text_q.push_back(filler());
        end
        1: begin
          if (pos < text_q.size()) text_q.delete(pos);
        end
        2: begin
          text_q.insert(pos, filler());
        end
        3: begin
          if (pos < text_q.size()) text_q[pos] = text_q[pos] ^ CASE_GAP;
        end
        default: begin
          text_q.push_back(filler());
        end
      endcase
    end
  endtask

  task automatic load_pattern(string s, logic [4:0] len);
    for (int i = 0; i < 16; i++) pat_b[i] = (i < s.len()) ? s[i] : 8'($urandom_range(255));
    pat_len_raw = len;
    program_pattern();
  endtask

  task automatic send_str(string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    send_string();
  endtask

  initial begin
    int start;
    sb = new();
    send_pct   = 0;
    stall_pct  = 0;
    noise_on   = 1'b0;
    items_sent = 0;
    rst_ni        <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_idx       <= CFG_CHARS_LOW;
    cfg_data      <= '0;
    text_ch.valid <= 1'b0;
    text_ch.data  <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset pattern is empty: only the empty string matches
    push_item(8'h5A, 1'b1, 1'b0);
    send_str("");
    send_str("a");

    drain();
    write_reg(CFG_UNUSED, {$urandom, $urandom});
    cfg_we <= 1'b0;
    send_str("");

    load_pattern("*", 5'd1);
    send_str("");
    send_str("Zq");

    load_pattern("a?C", 5'd3);
    send_str("AxC");
    send_str("aC");
    send_str("@?c");

    // Overlong length saturates; last slot reached only through a star chain
    for (int i = 0; i < 15; i++) pat_b[i] = CH_STAR;
    pat_b[15]   = 8'hFF;
    pat_len_raw = 5'd31;
    program_pattern();
    text_q = '{8'h00, 8'hFF};
    send_string();
    text_q = '{8'hFF, 8'h00};
    send_string();

    // Zero bytes are ordinary characters
    for (int i = 0; i < 16; i++) pat_b[i] = 8'($urandom_range(255));
    pat_b[0]    = 8'h00;
    pat_b[1]    = CH_QMARK;
    pat_len_raw = 5'd2;
    program_pattern();
    text_q = '{8'h00, 8'h00};
    send_string();
    text_q = '{8'h00};
    send_string();

    noise_on = 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          send_pct  = 52;
          stall_pct = 0;
        end
        2: begin
          send_pct  = 0;
          stall_pct = 52;
        end
        default: begin
          send_pct  = 26;
          stall_pct = 26;
        end
      endcase
      start = items_sent;
      while (items_sent - start < 375) begin
        random_pattern();
        program_pattern();
        repeat ($urandom_range(12, 4)) begin
          build_text();
          send_string();
        end
      end
    end

    drain();
    repeat (6) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
